// ===== sv/b32_pkg.sv =====
`timescale 1ns / 1ps
package b32_pkg;

  // widths of the address fields
  localparam int CHAR_W  = 7;
  localparam int GROUP_W = 5;
  localparam int CHK_W   = 30;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 2;

  // default length of one witness program and depth of the op queue
  localparam int PROGRAM_BYTES_DEF = 20;
  localparam int QUEUE_DEPTH_DEF   = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION       = 2'd2;

  // reset values of the registers
  localparam logic [CHAR_W-1:0]  PREFIX_FIRST_RST  = 7'd98;
  localparam logic [CHAR_W-1:0]  PREFIX_SECOND_RST = 7'd99;
  localparam logic [GROUP_W-1:0] VERSION_RST       = 5'd0;

  // separator character and checksum constants
  localparam logic [CHAR_W-1:0] CHAR_SEPARATOR = 7'h31;
  localparam logic [CHK_W-1:0]  CHK_INIT       = 30'd1;
  localparam logic [CHK_W-1:0]  CHK_FINAL_XOR  = 30'd1;
  localparam logic [CHK_W-1:0]  GEN [0:4] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  // one operation for the checksum and output side
  typedef struct packed {
    logic                feed;   // fold fval into the checksum
    logic [GROUP_W-1:0]  fval;
    logic                emit;   // send ch as an output character
    logic [CHAR_W-1:0]   ch;
    logic                check;  // close the checksum and send it
  } b32_op_t;

  // one polymod step
  function automatic logic [CHK_W-1:0] b32_feed(input logic [CHK_W-1:0] chk,
                                                input logic [GROUP_W-1:0] v);
    logic [GROUP_W-1:0] top;
    logic [CHK_W-1:0]   c;
    top = chk[CHK_W-1:CHK_W-GROUP_W];
    c = {chk[CHK_W-GROUP_W-1:0], v};
    for (int i = 0; i < GROUP_W; i++) begin
      if (top[i]) begin
        c = c ^ GEN[i];
      end
    end
    return c;
  endfunction

  // group to ascii character
  function automatic logic [CHAR_W-1:0] b32_alpha(input logic [GROUP_W-1:0] g);
    logic [CHAR_W-1:0] ch;
    unique case (g)
      5'd0:  ch = 7'h71; 5'd1:  ch = 7'h70; 5'd2:  ch = 7'h7a; 5'd3:  ch = 7'h72;
      5'd4:  ch = 7'h79; 5'd5:  ch = 7'h39; 5'd6:  ch = 7'h78; 5'd7:  ch = 7'h38;
      5'd8:  ch = 7'h67; 5'd9:  ch = 7'h66; 5'd10: ch = 7'h32; 5'd11: ch = 7'h74;
      5'd12: ch = 7'h76; 5'd13: ch = 7'h64; 5'd14: ch = 7'h77; 5'd15: ch = 7'h30;
      5'd16: ch = 7'h73; 5'd17: ch = 7'h33; 5'd18: ch = 7'h6a; 5'd19: ch = 7'h6e;
      5'd20: ch = 7'h35; 5'd21: ch = 7'h34; 5'd22: ch = 7'h6b; 5'd23: ch = 7'h68;
      5'd24: ch = 7'h63; 5'd25: ch = 7'h65; 5'd26: ch = 7'h36; 5'd27: ch = 7'h6d;
      5'd28: ch = 7'h75; 5'd29: ch = 7'h61; 5'd30: ch = 7'h37; 5'd31: ch = 7'h6c;
      default: ch = 7'h71;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/bech32_address_encoder.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// input     in         in_valid / in_stall  program_byte
// output    out        out_valid/out_stall  address_char, char_last
// config    in         cfg_write            cfg_index, cfg_data
//
// one op a cycle leaves the queue, unless the checksum is being closed or an
// emitting op waits on out_stall; a 20-byte program makes 39 ops (six header
// ops on the first byte, 32 groups, one close), and after the last byte the
// checksum is closed with six zero feeds, then six characters.
// rst is synchronous and clears the sequencers, queue and checksum; no sweep.
// out_stall only holds the back side; bytes keep entering until the queue fills.
module bech32_address_encoder import b32_pkg::*; #(
  parameter int PROGRAM_BYTES = PROGRAM_BYTES_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           program_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CHAR_W-1:0]    address_char,
  output logic                 char_last
);

  logic [CHAR_W-1:0]  prefix_first;
  logic [CHAR_W-1:0]  prefix_second;
  logic [GROUP_W-1:0] version;

  logic    q_full;
  logic    push;
  b32_op_t push_op;
  logic    pop;
  logic    q_valid;
  b32_op_t head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_first  <= PREFIX_FIRST_RST;
      prefix_second <= PREFIX_SECOND_RST;
      version       <= VERSION_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PREFIX_FIRST:  prefix_first  <= cfg_data;
        CFG_PREFIX_SECOND: prefix_second <= cfg_data;
        CFG_VERSION:       version       <= cfg_data[GROUP_W-1:0];
        default: ;
      endcase
    end
  end

  // byte regrouping and op generation
  b32_front #(
    .PROGRAM_BYTES(PROGRAM_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .program_byte (program_byte),
    .prefix_first (prefix_first),
    .prefix_second(prefix_second),
    .version      (version),
    .q_full       (q_full),
    .push         (push),
    .push_op      (push_op)
  );

  // op queue between the two sides
  b32_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .full   (q_full),
    .pop    (pop),
    .q_valid(q_valid),
    .head   (head)
  );

  // checksum and character output
  b32_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .address_char(address_char),
    .char_last   (char_last)
  );

endmodule

// ===== sv/b32_front.sv =====
`timescale 1ns / 1ps
module b32_front import b32_pkg::*; #(
  parameter int PROGRAM_BYTES = PROGRAM_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         program_byte,
  input  logic [CHAR_W-1:0]  prefix_first,
  input  logic [CHAR_W-1:0]  prefix_second,
  input  logic [GROUP_W-1:0] version,
  input  logic               q_full,
  output logic               push,
  output b32_op_t            push_op
);

  localparam int CNT_W = (PROGRAM_BYTES > 2) ? $clog2(PROGRAM_BYTES) : 1;
  localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(PROGRAM_BYTES - 1);

  typedef enum logic [2:0] {PH_IDLE, PH_HDR, PH_GRP, PH_PAD, PH_CHK} phase_t;

  phase_t             phase;
  logic [2:0]         hdr_idx;
  logic [11:0]        acc;
  logic [3:0]         nbits;
  logic               is_last;
  logic [CNT_W-1:0]   bytes_seen;
  logic [CHAR_W-1:0]  c1;
  logic [CHAR_W-1:0]  c2;
  logic [GROUP_W-1:0] ver;

  logic               ready;
  logic               accept;
  logic [3:0]         grp_after;
  logic               grp_done;
  logic [3:0]         left_n;
  logic [11:0]        grp_shift;
  logic [GROUP_W-1:0] grp_val;
  logic [8:0]         pad_shift;
  logic [GROUP_W-1:0] pad_val;

  // grouping arithmetic
  assign push      = (phase != PH_IDLE) && !q_full;
  assign grp_after = nbits - 4'd5;
  assign grp_done  = grp_after < 4'd5;
  assign left_n    = (phase == PH_GRP) ? grp_after : nbits;
  assign grp_shift = acc >> grp_after;
  assign grp_val   = grp_shift[GROUP_W-1:0];
  assign pad_shift = {5'd0, acc[3:0]} << (4'd5 - nbits);
  assign pad_val   = pad_shift[GROUP_W-1:0];

  // input is taken when idle or on the last push of the current byte
  always_comb begin
    ready = (phase == PH_IDLE) ||
            (push && (phase == PH_GRP) && grp_done && !is_last) ||
            (push && (phase == PH_CHK));
  end
  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  // operation for the current step
  always_comb begin
    push_op = '0;
    unique case (phase)
      PH_HDR: begin
        push_op.feed = 1'b1;
        unique case (hdr_idx)
          3'd0: begin
            push_op.fval = {3'd0, c1[6:5]};
            push_op.emit = 1'b1;
            push_op.ch   = c1;
          end
          3'd1: begin
            push_op.fval = {3'd0, c2[6:5]};
            push_op.emit = 1'b1;
            push_op.ch   = c2;
          end
          3'd2: begin
            push_op.fval = '0;
            push_op.emit = 1'b1;
            push_op.ch   = CHAR_SEPARATOR;
          end
          3'd3: begin
            push_op.fval = c1[4:0];
            push_op.emit = 1'b1;
            push_op.ch   = b32_alpha(ver);
          end
          3'd4: push_op.fval = c2[4:0];
          default: push_op.fval = ver;
        endcase
      end
      PH_GRP: begin
        push_op.feed = 1'b1;
        push_op.fval = grp_val;
        push_op.emit = 1'b1;
        push_op.ch   = b32_alpha(grp_val);
      end
      PH_PAD: begin
        push_op.feed = 1'b1;
        push_op.fval = pad_val;
        push_op.emit = 1'b1;
        push_op.ch   = b32_alpha(pad_val);
      end
      PH_CHK: push_op.check = 1'b1;
      default: push_op = '0;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hdr_idx    <= '0;
      nbits      <= '0;
      is_last    <= 1'b0;
      bytes_seen <= '0;
    end else begin
      // steps of the byte in progress
      if (push) begin
        unique case (phase)
          PH_HDR: begin
            hdr_idx <= hdr_idx + 3'd1;
            if (hdr_idx == 3'd5) begin
              phase <= PH_GRP;
            end
          end
          PH_GRP: begin
            nbits <= grp_after;
            if (grp_done) begin
              if (!is_last) begin
                phase <= PH_IDLE;
              end else if (grp_after != 4'd0) begin
                phase <= PH_PAD;
              end else begin
                phase <= PH_CHK;
              end
            end
          end
          PH_PAD: begin
            nbits <= '0;
            phase <= PH_CHK;
          end
          PH_CHK: phase <= PH_IDLE;
          default: phase <= PH_IDLE;
        endcase
      end
      // new byte transaction
      if (accept) begin
        acc     <= {acc[3:0], program_byte};
        nbits   <= left_n + 4'd8;
        is_last <= (bytes_seen == LAST_BYTE);
        if (bytes_seen == LAST_BYTE) begin
          bytes_seen <= '0;
        end else begin
          bytes_seen <= bytes_seen + CNT_W'(1);
        end
        if (bytes_seen == '0) begin
          c1      <= prefix_first;
          c2      <= prefix_second;
          ver     <= version;
          hdr_idx <= '0;
          phase   <= PH_HDR;
        end else begin
          phase <= PH_GRP;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_leftover: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (nbits <= 4'd4))
    else $error("leftover count too large while idle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (phase == PH_HDR || phase == PH_GRP))
    else $error("accepted byte not being worked on");
  a_pad_state: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAD) |-> (nbits != 4'd0 && nbits < 4'd5 && is_last))
    else $error("padding group outside last byte");
`endif

endmodule

// ===== sv/b32_queue.sv =====
`timescale 1ns / 1ps
module b32_queue import b32_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  b32_op_t push_op,
  output logic    full,
  input  logic    pop,
  output logic    q_valid,
  output b32_op_t head
);

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  b32_op_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_FULL);
  assign q_valid = (count != '0);
  assign head    = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/b32_back.sv =====
`timescale 1ns / 1ps
module b32_back import b32_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  b32_op_t           head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] address_char,
  output logic              char_last
);

  typedef enum logic [1:0] {B_RUN, B_ZERO, B_OUT} bstate_t;

  bstate_t            state;
  logic [2:0]         cnt;
  logic [CHK_W-1:0]   chk;

  logic               out_free;
  logic [CHK_W-1:0]   chk_x;
  logic [GROUP_W-1:0] sym;

  assign out_free = !out_valid || !out_stall;
  assign chk_x    = chk ^ CHK_FINAL_XOR;

  // checksum symbol, most significant first
  always_comb begin
    unique case (cnt)
      3'd0: sym = chk_x[29:25];
      3'd1: sym = chk_x[24:20];
      3'd2: sym = chk_x[19:15];
      3'd3: sym = chk_x[14:10];
      3'd4: sym = chk_x[9:5];
      default: sym = chk_x[4:0];
    endcase
  end

  // take the head op in the run state when it needs no output slot or the slot is free
  always_comb begin
    pop = (state == B_RUN) && q_valid && (head.check || !head.emit || out_free);
  end

  // checksum, sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_RUN;
      cnt       <= '0;
      chk       <= CHK_INIT;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_RUN: begin
          if (pop) begin
            if (head.check) begin
              state <= B_ZERO;
              cnt   <= '0;
            end else begin
              if (head.feed) begin
                chk <= b32_feed(chk, head.fval);
              end
              if (head.emit) begin
                out_valid    <= 1'b1;
                address_char <= head.ch;
                char_last    <= 1'b0;
              end
            end
          end
        end
        B_ZERO: begin
          chk <= b32_feed(chk, '0);
          if (cnt == 3'd5) begin
            state <= B_OUT;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        B_OUT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            address_char <= b32_alpha(sym);
            char_last    <= (cnt == 3'd5);
            if (cnt == 3'd5) begin
              chk   <= CHK_INIT;
              state <= B_RUN;
              cnt   <= '0;
            end else begin
              cnt <= cnt + 3'd1;
            end
          end
        end
        default: state <= B_RUN;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != B_RUN) |-> !pop)
    else $error("op taken while closing checksum");
  a_chk_restart: assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT && out_free && cnt == 3'd5) |=> (chk == CHK_INIT && state == B_RUN))
    else $error("checksum not restarted after last character");
  a_check_start: assert property (@(posedge clk) disable iff (rst)
    (pop && head.check) |=> (state == B_ZERO && cnt == 3'd0))
    else $error("checksum close did not start");
`endif

endmodule
